[hdl/wmd_pkg.sv]
// ----------------------------------------------------------------------------
// wmd_pkg
// Shared constants and types for the windowed median displacement core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

  // default history depth in samples
  localparam int HISTORY_DEPTH = 20;

  // sample and displacement widths
  localparam int POS_W  = 16;
  localparam int DISP_W = POS_W + 1;

  // bus widths, packed fields padded to whole bytes
  localparam int IN_DATA_W  = 2 * POS_W;
  localparam int OUT_FLD_W  = 2 * POS_W + 2 * DISP_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_WAIT
  } wmd_state_t;

  // median pairs handed to the merge stage
  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [POS_W-1:0] old_x;
    logic signed [POS_W-1:0] old_y;
  } wmd_medians_t;

endpackage

`default_nettype wire

[hdl/windowed_median_displacement_core.sv]
// ----------------------------------------------------------------------------
// windowed_median_displacement_core
// Keeps the last HISTORY_DEPTH positions and reports the newer-half medians
// and their displacement against the older-half medians.
// ----------------------------------------------------------------------------
// Sequence: an accepted input moves the sequencer through ST_LOAD, ST_RUN and
//   ST_WAIT; in ST_RUN the rank lanes step one window entry per cycle, and in
//   ST_WAIT the result is loaded into the output register once it is free.
// Input: a new input is taken only in ST_IDLE, after the previous result has
//   left ST_WAIT; the next input can be taken while a finished result still
//   waits in the output register.
// Reset: synchronous active-low rst_n zeroes the history and clears control.
`timescale 1ns / 1ps
`default_nettype none

module windowed_median_displacement_core #(
  parameter int HISTORY_DEPTH = wmd_pkg::HISTORY_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // fields from bit 0: pos_x[15:0], pos_y[15:0]
  input  wire logic [wmd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // fields from bit 0: median_x[15:0], median_y[15:0], disp_x[16:0], disp_y[16:0]
  output logic [wmd_pkg::OUT_DATA_W-1:0]         out_tdata
);

  localparam int HALF = HISTORY_DEPTH / 2;
  localparam int RANK = HALF / 2;
  localparam int PW   = wmd_pkg::POS_W;

  wmd_pkg::wmd_state_t state_r, state_nxt;

  logic [PW-1:0] hist_x_r [HISTORY_DEPTH];
  logic [PW-1:0] hist_y_r [HISTORY_DEPTH];

  logic [HALF-1:0][PW-1:0] win_nx;
  logic [HALF-1:0][PW-1:0] win_ny;
  logic [HALF-1:0][PW-1:0] win_ox;
  logic [HALF-1:0][PW-1:0] win_oy;

  logic                   in_acc;
  logic                   lane_start;
  logic [3:0]             lane_done;
  wmd_pkg::wmd_medians_t  med;
  logic                   mrg_valid;
  logic                   mrg_ready;

  assign in_acc = in_tvalid && in_tready;

  // history shift line, newest at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_x_r[k] <= '0;
        hist_y_r[k] <= '0;
      end
    end else if (in_acc) begin
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
        hist_x_r[k] <= hist_x_r[k - 1];
        hist_y_r[k] <= hist_y_r[k - 1];
      end
      hist_x_r[0] <= in_tdata[PW-1:0];
      hist_y_r[0] <= in_tdata[2*PW-1:PW];
    end
  end

  // half windows for the lanes
  for (genvar g = 0; g < HALF; g++) begin : g_win
    assign win_nx[g] = hist_x_r[g];
    assign win_ny[g] = hist_y_r[g];
    assign win_ox[g] = hist_x_r[HALF + g];
    assign win_oy[g] = hist_y_r[HALF + g];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    lane_start = 1'b0;
    mrg_valid  = 1'b0;
    case (state_r)
      wmd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = wmd_pkg::ST_LOAD;
        end
      end
      wmd_pkg::ST_LOAD: begin
        lane_start = 1'b1;
        state_nxt  = wmd_pkg::ST_RUN;
      end
      wmd_pkg::ST_RUN: begin
        if (&lane_done) begin
          state_nxt = wmd_pkg::ST_WAIT;
        end
      end
      wmd_pkg::ST_WAIT: begin
        mrg_valid = 1'b1;
        if (mrg_ready) begin
          state_nxt = wmd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmd_pkg::ST_IDLE;
      end
    endcase
  end

  // four rank lanes: newer x, newer y, older x, older y
  wmd_lane #(.HALF(HALF), .RANK(RANK)) u_lane_nx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (lane_start),
    .win_i    (win_nx),
    .done_o   (lane_done[0]),
    .median_o (med.new_x)
  );

  wmd_lane #(.HALF(HALF), .RANK(RANK)) u_lane_ny (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (lane_start),
    .win_i    (win_ny),
    .done_o   (lane_done[1]),
    .median_o (med.new_y)
  );

  wmd_lane #(.HALF(HALF), .RANK(RANK)) u_lane_ox (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (lane_start),
    .win_i    (win_ox),
    .done_o   (lane_done[2]),
    .median_o (med.old_x)
  );

  wmd_lane #(.HALF(HALF), .RANK(RANK)) u_lane_oy (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (lane_start),
    .win_i    (win_oy),
    .done_o   (lane_done[3]),
    .median_o (med.old_y)
  );

  // merge stage and output register
  wmd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .mrg_valid_i (mrg_valid),
    .mrg_ready_o (mrg_ready),
    .med_i       (med),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

[hdl/wmd_lane.sv]
// ----------------------------------------------------------------------------
// wmd_lane
// Rank selector over one half window: every candidate keeps a rank counter,
// the window is rotated past all candidates one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmd_lane #(
  parameter int HALF = wmd_pkg::HISTORY_DEPTH / 2,
  parameter int RANK = HALF / 2
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      start_i,
  input  wire logic [HALF-1:0][wmd_pkg::POS_W-1:0]       win_i,
  output logic                                           done_o,
  output logic signed [wmd_pkg::POS_W-1:0]               median_o
);

  localparam int CW = $clog2(HALF + 1);

  logic signed [wmd_pkg::POS_W-1:0] cand_r [HALF];
  logic signed [wmd_pkg::POS_W-1:0] rot_r  [HALF];
  logic signed [wmd_pkg::POS_W-1:0] rot_nxt [HALF];
  logic [CW-1:0]                    rank_r [HALF];
  logic [CW-1:0]                    cnt_r;
  logic                             run_r;
  logic                             sel_r;
  logic                             done_r;
  logic signed [wmd_pkg::POS_W-1:0] median_r;
  logic signed [wmd_pkg::POS_W-1:0] median_nxt;

  // rotate the window one place each cycle while running, entry 0 is the compare tap
  always_comb begin
    for (int k = 0; k < HALF - 1; k++) begin
      rot_nxt[k] = rot_r[k + 1];
    end
    rot_nxt[HALF-1] = rot_r[0];
  end

  // control: load, run over all entries, then select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      sel_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= sel_r;
      sel_r  <= 1'b0;
      if (start_i) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CW'(HALF - 1)) begin
          run_r <= 1'b0;
          sel_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // candidates and rank counters; ties broken by window position
  always_ff @(posedge clk) begin
    for (int i = 0; i < HALF; i++) begin
      if (start_i) begin
        cand_r[i] <= $signed(win_i[i]);
        rot_r[i]  <= $signed(win_i[i]);
        rank_r[i] <= '0;
      end else if (run_r) begin
        rot_r[i] <= rot_nxt[i];
        if ((rot_r[0] < cand_r[i]) ||
            ((rot_r[0] == cand_r[i]) && (cnt_r < CW'(i)))) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // exactly one candidate holds the wanted rank
  always_comb begin
    median_nxt = '0;
    for (int i = 0; i < HALF; i++) begin
      if (rank_r[i] == CW'(RANK)) begin
        median_nxt = median_nxt | cand_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel_r) begin
      median_r <= median_nxt;
    end
  end

  assign done_o   = done_r;
  assign median_o = median_r;

endmodule

`default_nettype wire

[hdl/wmd_merge.sv]
// ----------------------------------------------------------------------------
// wmd_merge
// Merges the four lane medians into one result and holds it in the output
// register until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmd_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  mrg_valid_i,
  output logic                                       mrg_ready_o,
  input  wire wmd_pkg::wmd_medians_t                 med_i,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // fields from bit 0: median_x[15:0], median_y[15:0], disp_x[16:0], disp_y[16:0]
  output logic [wmd_pkg::OUT_DATA_W-1:0]             out_tdata
);

  logic                                 vld_r;
  logic signed [wmd_pkg::POS_W-1:0]     mx_r;
  logic signed [wmd_pkg::POS_W-1:0]     my_r;
  logic signed [wmd_pkg::DISP_W-1:0]    dx_r;
  logic signed [wmd_pkg::DISP_W-1:0]    dy_r;
  logic signed [wmd_pkg::DISP_W-1:0]    dx_nxt;
  logic signed [wmd_pkg::DISP_W-1:0]    dy_nxt;
  logic                                 load;

  // output register free or emptied this cycle
  assign mrg_ready_o = !vld_r || out_tready;
  assign load        = mrg_valid_i && mrg_ready_o;

  // newer minus older, one bit wider so it never wraps
  assign dx_nxt = wmd_pkg::DISP_W'(med_i.new_x) - wmd_pkg::DISP_W'(med_i.old_x);
  assign dy_nxt = wmd_pkg::DISP_W'(med_i.new_y) - wmd_pkg::DISP_W'(med_i.old_y);

  // valid flag of the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      mx_r <= med_i.new_x;
      my_r <= med_i.new_y;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {{(wmd_pkg::OUT_DATA_W - wmd_pkg::OUT_FLD_W){1'b0}},
                       dy_r, dx_r, my_r, mx_r};

endmodule

`default_nettype wire
